// ----- src/rsk_pkg.sv -----
// Package: shared constants, payload types and arithmetic unit request and response types.
`default_nettype none
package rsk_pkg;

  localparam int PRIME_BITS = 16;
  localparam int PRIME_W    = 16;
  localparam int WORD_W     = 32;
  localparam int CNT_W      = $clog2(WORD_W);

  localparam logic [PRIME_W-1:0] PrimeMask =
      (PRIME_BITS >= PRIME_W) ? {PRIME_W{1'b1}} : PRIME_W'((1 << PRIME_BITS) - 1);

  localparam logic [1:0] CFG_PRIME_FIRST  = 2'd0;
  localparam logic [1:0] CFG_PRIME_SECOND = 2'd1;

  localparam logic [PRIME_W-1:0] PRIME_FIRST_RST  = 16'd61;
  localparam logic [PRIME_W-1:0] PRIME_SECOND_RST = 16'd53;

  typedef enum logic {
    ALU_DIV = 1'b0,
    ALU_MUL = 1'b1
  } alu_op_e;

  typedef struct packed {
    logic                kind;
    logic [WORD_W-1:0]   message_value;
  } in_item_t;

  typedef struct packed {
    logic [WORD_W-1:0]   result_value;
    logic                status;
    logic [WORD_W-1:0]   public_exponent;
    logic [WORD_W-1:0]   private_exponent;
  } out_item_t;

  // a: dividend or multiplicand, b: divisor or multiplier, m: modulus
  typedef struct packed {
    logic                start;
    alu_op_e             op;
    logic [WORD_W-1:0]   a;
    logic [WORD_W-1:0]   b;
    logic [WORD_W-1:0]   m;
  } alu_req_t;

  typedef struct packed {
    logic                done;
    logic [WORD_W-1:0]   quo;
    logic [WORD_W-1:0]   rem;
  } alu_rsp_t;

endpackage
`default_nettype wire

// ----- src/rsk_alu.sv -----
// Bit-serial shared unit: restoring divide and shift-add modular multiply.
`default_nettype none
module rsk_alu (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  rsk_pkg::alu_req_t  req_i,
  output rsk_pkg::alu_rsp_t  rsp_o
);

  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  logic [rsk_pkg::CNT_W-1:0]     cnt_q, cnt_d;
  rsk_pkg::alu_op_e              op_q, op_d;
  logic [rsk_pkg::WORD_W-1:0]    x_q, x_d;   // remainder or accumulator
  logic [rsk_pkg::WORD_W-1:0]    y_q, y_d;   // dividend/quotient or multiplier
  logic [rsk_pkg::WORD_W-1:0]    a_q, a_d;   // divisor or multiplicand
  logic [rsk_pkg::WORD_W-1:0]    m_q, m_d;

  logic [rsk_pkg::WORD_W:0]      div_t;
  logic [rsk_pkg::WORD_W+1:0]    div_s;
  logic [rsk_pkg::WORD_W+1:0]    mul_s;
  logic [rsk_pkg::WORD_W+2:0]    mul_s1, mul_s2;

  always_comb begin
    div_t  = {x_q, y_q[rsk_pkg::WORD_W-1]};
    div_s  = {1'b0, div_t} - {2'b00, a_q};
    mul_s  = {1'b0, x_q, 1'b0} + (y_q[rsk_pkg::WORD_W-1] ? {2'b00, a_q} : '0);
    mul_s1 = {1'b0, mul_s} - {3'b000, m_q};
    mul_s2 = {1'b0, mul_s} - {2'b00, m_q, 1'b0};
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    op_d   = op_q;
    x_d    = x_q;
    y_d    = y_q;
    a_d    = a_q;
    m_d    = m_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      op_d   = req_i.op;
      x_d    = '0;
      a_d    = (req_i.op == rsk_pkg::ALU_DIV) ? req_i.b : req_i.a;
      y_d    = (req_i.op == rsk_pkg::ALU_DIV) ? req_i.a : req_i.b;
      m_d    = req_i.m;
    end else if (busy_q) begin
      cnt_d = cnt_q + 1'b1;
      if (op_q == rsk_pkg::ALU_DIV) begin
        if (!div_s[rsk_pkg::WORD_W+1]) begin
          x_d = div_s[rsk_pkg::WORD_W-1:0];
          y_d = {y_q[rsk_pkg::WORD_W-2:0], 1'b1};
        end else begin
          x_d = div_t[rsk_pkg::WORD_W-1:0];
          y_d = {y_q[rsk_pkg::WORD_W-2:0], 1'b0};
        end
      end else begin
        y_d = {y_q[rsk_pkg::WORD_W-2:0], 1'b0};
        if (!mul_s2[rsk_pkg::WORD_W+2]) begin
          x_d = mul_s2[rsk_pkg::WORD_W-1:0];
        end else if (!mul_s1[rsk_pkg::WORD_W+2]) begin
          x_d = mul_s1[rsk_pkg::WORD_W-1:0];
        end else begin
          x_d = mul_s[rsk_pkg::WORD_W-1:0];
        end
      end
      if (cnt_q == rsk_pkg::CNT_W'(rsk_pkg::WORD_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      op_q   <= rsk_pkg::ALU_DIV;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
      op_q   <= op_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    a_q <= a_d;
    m_q <= m_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = y_q;
  assign rsp_o.rem  = x_q;

endmodule
`default_nettype wire

// ----- src/rsa_small_key_cipher_unit.sv -----
// Top level: textbook RSA key derivation and modular exponentiation sequencer.
//
//  port group     | dir | handshake            | word
//  ---------------+-----+----------------------+----------------------------------
//  in_*           | in  | in_valid_i/in_stall_o | kind, message_value
//  out_*          | out | out_valid_o/out_stall_i | result, status, e, d
//  cfg_*          | in  | cfg_valid_i/cfg_ready_o | prime index, 16-bit prime
//
//  Every divide or modular multiply runs on the shared bit-serial unit. Each exponent
//  bit takes a test, a multiply when the bit is set, and a square; key derivation (gcd
//  search and inverse) adds its divides to the first word after reset or a prime write.
//  Reset loads primes 61 and 53 and marks keys not derived.
//  Input stalls while a word is at work; a finished word holds in the output register
//  until taken, and the next word is accepted meanwhile.
`default_nettype none
module rsa_small_key_cipher_unit (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  rsk_pkg::in_item_t               in_item_i,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output rsk_pkg::out_item_t              out_item_o,
  input  wire logic                       cfg_valid_i,
  output logic                            cfg_ready_o,
  input  wire logic [1:0]                 cfg_index_i,
  input  wire logic [rsk_pkg::PRIME_W-1:0] cfg_data_i
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_KEY      = 4'd1;
  localparam logic [3:0] S_CHK      = 4'd2;
  localparam logic [3:0] S_GCD_TEST = 4'd3;
  localparam logic [3:0] S_GCD_WAIT = 4'd4;
  localparam logic [3:0] S_INV_TEST = 4'd5;
  localparam logic [3:0] S_INV_DIV  = 4'd6;
  localparam logic [3:0] S_INV_MUL  = 4'd7;
  localparam logic [3:0] S_RED      = 4'd8;
  localparam logic [3:0] S_RED_WAIT = 4'd9;
  localparam logic [3:0] S_EXP_TEST = 4'd10;
  localparam logic [3:0] S_EXP_MA   = 4'd11;
  localparam logic [3:0] S_EXP_SQ   = 4'd12;
  localparam logic [3:0] S_OUT      = 4'd13;

  localparam int W = rsk_pkg::WORD_W;

  logic [3:0]                  state_q, state_d;
  logic [rsk_pkg::PRIME_W-1:0] p_q, p_d, q_q, q_d;
  logic                        key_ready_q, key_ready_d;
  logic                        invalid_q, invalid_d;
  logic [W-1:0]                n_q, n_d, phi_q, phi_d, e_q, e_d, dexp_q, dexp_d;
  logic                        kind_q, kind_d;
  logic [W-1:0]                msg_q, msg_d;
  // gcd / extended Euclid / exponent working registers
  logic [W-1:0]                ga_q, ga_d, gb_q, gb_d;
  logic [W-1:0]                t0_q, t0_d, t1_q, t1_d, rtmp_q, rtmp_d;
  logic [W-1:0]                acc_q, acc_d, base_q, base_d, exp_q, exp_d;
  logic                        out_valid_q, out_valid_d;
  rsk_pkg::out_item_t          out_q, out_d;

  rsk_pkg::alu_req_t           alu_req;
  rsk_pkg::alu_rsp_t           alu_rsp;

  logic                        in_acc;
  logic [rsk_pkg::PRIME_W-1:0] pm1, qm1;
  logic [W-1:0]                tdiff;

  rsk_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (alu_req),
    .rsp_o  (alu_rsp)
  );

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  always_comb begin
    pm1   = (p_q == '0) ? '0 : p_q - 1'b1;
    qm1   = (q_q == '0) ? '0 : q_q - 1'b1;
    // t0 - q*t1 mod phi, with the product already reduced
    tdiff = (t0_q >= alu_rsp.rem) ? t0_q - alu_rsp.rem : t0_q - alu_rsp.rem + phi_q;
  end

  always_comb begin
    state_d     = state_q;
    p_d         = p_q;
    q_d         = q_q;
    key_ready_d = key_ready_q;
    invalid_d   = invalid_q;
    n_d         = n_q;
    phi_d       = phi_q;
    e_d         = e_q;
    dexp_d      = dexp_q;
    kind_d      = kind_q;
    msg_d       = msg_q;
    ga_d        = ga_q;
    gb_d        = gb_q;
    t0_d        = t0_q;
    t1_d        = t1_q;
    rtmp_d      = rtmp_q;
    acc_d       = acc_q;
    base_d      = base_q;
    exp_d       = exp_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    alu_req     = '{start: 1'b0, op: rsk_pkg::ALU_DIV, a: '0, b: '0, m: '0};

    // prime writes: mask to the prime width, force key rederivation
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        rsk_pkg::CFG_PRIME_FIRST: begin
          p_d         = cfg_data_i & rsk_pkg::PrimeMask;
          key_ready_d = 1'b0;
        end
        rsk_pkg::CFG_PRIME_SECOND: begin
          q_d         = cfg_data_i & rsk_pkg::PrimeMask;
          key_ready_d = 1'b0;
        end
        default: ;
      endcase
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          kind_d = in_item_i.kind;
          msg_d  = in_item_i.message_value;
          if (!key_ready_q) begin
            state_d = S_KEY;
          end else if (invalid_q) begin
            state_d = S_OUT;
          end else begin
            state_d = S_RED;
          end
        end
      end
      S_KEY: begin
        n_d         = W'(p_q) * W'(q_q);
        phi_d       = W'(pm1) * W'(qm1);
        key_ready_d = 1'b1;
        state_d     = S_CHK;
      end
      S_CHK: begin
        if (phi_q < W'(3) || n_q == '0) begin
          invalid_d = 1'b1;
          e_d       = '0;
          dexp_d    = '0;
          state_d   = S_OUT;
        end else begin
          invalid_d = 1'b0;
          e_d       = W'(2);
          ga_d      = W'(2);
          gb_d      = phi_q;
          state_d   = S_GCD_TEST;
        end
      end
      S_GCD_TEST: begin
        if (ga_q == '0) begin
          // gcd is in gb; advance e unless coprime, stop once coprime or e+1 reaches phi
          if (gb_q == W'(1) || e_q + W'(1) >= phi_q) begin
            if (gb_q != W'(1)) e_d = e_q + W'(1);
            rtmp_d  = '0;
            ga_d    = phi_q;
            gb_d    = (gb_q == W'(1)) ? e_q : '0;
            t0_d    = '0;
            t1_d    = W'(1);
            state_d = S_INV_TEST;
          end else begin
            e_d  = e_q + W'(1);
            ga_d = e_q + W'(1);
            gb_d = phi_q;
          end
        end else begin
          alu_req = '{start: 1'b1, op: rsk_pkg::ALU_DIV, a: gb_q, b: ga_q, m: '0};
          state_d = S_GCD_WAIT;
        end
      end
      S_GCD_WAIT: begin
        if (alu_rsp.done) begin
          gb_d    = ga_q;
          ga_d    = alu_rsp.rem;
          state_d = S_GCD_TEST;
        end
      end
      // extended Euclid: ga holds r0, gb holds r1, t kept mod phi
      S_INV_TEST: begin
        if (gb_q == '0) begin
          dexp_d  = t0_q;
          state_d = S_RED;
        end else begin
          alu_req = '{start: 1'b1, op: rsk_pkg::ALU_DIV, a: ga_q, b: gb_q, m: '0};
          state_d = S_INV_DIV;
        end
      end
      S_INV_DIV: begin
        if (alu_rsp.done) begin
          rtmp_d  = alu_rsp.rem;
          alu_req = '{start: 1'b1, op: rsk_pkg::ALU_MUL, a: t1_q, b: alu_rsp.quo, m: phi_q};
          state_d = S_INV_MUL;
        end
      end
      S_INV_MUL: begin
        if (alu_rsp.done) begin
          ga_d    = gb_q;
          gb_d    = rtmp_q;
          t0_d    = t1_q;
          t1_d    = tdiff;
          state_d = S_INV_TEST;
        end
      end
      S_RED: begin
        if (invalid_q) begin
          state_d = S_OUT;
        end else begin
          alu_req = '{start: 1'b1, op: rsk_pkg::ALU_DIV, a: msg_q, b: n_q, m: '0};
          state_d = S_RED_WAIT;
        end
      end
      S_RED_WAIT: begin
        if (alu_rsp.done) begin
          base_d  = alu_rsp.rem;
          acc_d   = W'(1);
          exp_d   = kind_q ? dexp_q : e_q;
          state_d = S_EXP_TEST;
        end
      end
      S_EXP_TEST: begin
        if (exp_q == '0) begin
          state_d = S_OUT;
        end else if (exp_q[0]) begin
          alu_req = '{start: 1'b1, op: rsk_pkg::ALU_MUL, a: acc_q, b: base_q, m: n_q};
          state_d = S_EXP_MA;
        end else begin
          alu_req = '{start: 1'b1, op: rsk_pkg::ALU_MUL, a: base_q, b: base_q, m: n_q};
          state_d = S_EXP_SQ;
        end
      end
      S_EXP_MA: begin
        if (alu_rsp.done) begin
          acc_d   = alu_rsp.rem;
          alu_req = '{start: 1'b1, op: rsk_pkg::ALU_MUL, a: base_q, b: base_q, m: n_q};
          state_d = S_EXP_SQ;
        end
      end
      S_EXP_SQ: begin
        if (alu_rsp.done) begin
          base_d  = alu_rsp.rem;
          exp_d   = exp_q >> 1;
          state_d = S_EXP_TEST;
        end
      end
      S_OUT: begin
        // hold until the output register is free
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          if (invalid_q) begin
            out_d = '{result_value: '0, status: 1'b1, public_exponent: '0,
                      private_exponent: '0};
          end else begin
            out_d = '{result_value: acc_q, status: 1'b0, public_exponent: e_q,
                      private_exponent: dexp_q};
          end
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      p_q         <= rsk_pkg::PRIME_FIRST_RST;
      q_q         <= rsk_pkg::PRIME_SECOND_RST;
      key_ready_q <= 1'b0;
      invalid_q   <= 1'b0;
      n_q         <= '0;
      phi_q       <= '0;
      e_q         <= '0;
      dexp_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      p_q         <= p_d;
      q_q         <= q_d;
      key_ready_q <= key_ready_d;
      invalid_q   <= invalid_d;
      n_q         <= n_d;
      phi_q       <= phi_d;
      e_q         <= e_d;
      dexp_q      <= dexp_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    msg_q  <= msg_d;
    ga_q   <= ga_d;
    gb_q   <= gb_d;
    t0_q   <= t0_d;
    t1_q   <= t1_d;
    rtmp_q <= rtmp_d;
    acc_q  <= acc_d;
    base_q <= base_d;
    exp_q  <= exp_d;
    out_q  <= out_d;
  end

  // unit answers only while the sequencer waits on it
  a_alu_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
      alu_rsp.done |-> (state_q == S_GCD_WAIT || state_q == S_INV_DIV ||
                        state_q == S_INV_MUL || state_q == S_RED_WAIT ||
                        state_q == S_EXP_MA || state_q == S_EXP_SQ))
    else $error("arithmetic unit done outside a wait state");

  // an invalid key reports all-zero numbers
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (out_valid_o && out_item_o.status) |->
      (out_item_o.result_value == '0 && out_item_o.public_exponent == '0 &&
       out_item_o.private_exponent == '0))
    else $error("invalid key word carries nonzero fields");

  // an accepted word always leaves idle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (in_valid_i && !in_stall_o) |=> (state_q != S_IDLE))
    else $error("accepted word did not start");

endmodule
`default_nettype wire
